>>> rtl/pow_target_retarget_defines.svh
// Assertion macros shared by the retarget block.
`ifndef POW_TARGET_RETARGET_DEFINES_SVH
`define POW_TARGET_RETARGET_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define PTR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("retarget assertion failed");
// Implication in the same cycle.
`define PTR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("retarget assertion failed");
// Implication into the next cycle.
`define PTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("retarget assertion failed");
`else
`define PTR_ASSERT(lbl, prop)
`define PTR_ASSERT_IMPL(lbl, ante, cons)
`define PTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/ptr_pkg.sv
// Shared types and constants of the difficulty retarget block.
`default_nettype none
package ptr_pkg;
    // Width of the expanded target; a multiple of 8 between 64 and 256.
    localparam int TARGET_BITS = 256;
    localparam int SPAN_W = 34;
    localparam int DIV_W = 32;
    localparam int NBYTES = TARGET_BITS / 8;
    localparam int NB_W = $clog2(NBYTES + 1);
    localparam int CNT_W = $clog2(TARGET_BITS + 1);
    localparam int ADJ_BASE = 100;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_LEGACY_SPAN = 3'd0,
        REG_AVG_SPAN    = 3'd1,
        REG_AVG_MIN     = 3'd2,
        REG_AVG_MAX     = 3'd3,
        REG_ADJUST      = 3'd4,
        REG_ZERO_BITS   = 3'd5,
        REG_NO_RETARGET = 3'd6
    } reg_idx_t;

    // How the back end treats an item.
    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_KEEP   = 2'd1,
        KIND_LEGACY = 2'd2,
        KIND_AVG    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] legacy_span;
        logic [31:0] avg_span;
        logic [31:0] avg_min;
        logic [31:0] avg_max;
        logic [15:0] adjust;
        logic [7:0]  zero_bits;
        logic        no_retarget;
    } cfg_t;

    typedef struct packed {
        kind_t                   kind;
        logic [31:0]             prev_bits;
        logic [SPAN_W-1:0]       span;
        logic [TARGET_BITS-1:0]  value;
    } entry_t;
endpackage
`default_nettype wire

>>> rtl/ptr_front.sv
// Front end: classifies an item, clamps its time span and expands the target.
`default_nettype none
module ptr_front
    import ptr_pkg::*;
(
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [31:0] s_prev_bits,
    input  wire logic [31:0] s_first_time,
    input  wire logic [31:0] s_last_time,
    input  wire logic        s_chain_short,
    input  wire cfg_t        cfg,
    input  wire logic        q_full,
    output logic             push,
    output entry_t           entry
);
    logic signed [34:0] diff;
    logic signed [34:0] lo;
    logic signed [34:0] hi;
    logic signed [34:0] sp_lo;
    logic signed [34:0] sp_hi;
    logic [7:0]         size;
    logic [7:0]         shift;
    logic [10:0]        sh_bits;
    logic [TARGET_BITS-1:0] word_ext;

    assign s_ready = !q_full;
    assign push = s_valid && !q_full;

    // Span clamp: low bound first, then high bound.
    always_comb begin
        diff = $signed({3'b000, s_last_time}) - $signed({3'b000, s_first_time});
        if (s_mode) begin
            lo = $signed({3'b000, cfg.avg_min});
            hi = $signed({3'b000, cfg.avg_max});
        end else begin
            lo = $signed({5'b00000, cfg.legacy_span[31:2]});
            hi = $signed({1'b0, cfg.legacy_span, 2'b00});
        end
        sp_lo = (diff < lo) ? lo : diff;
        sp_hi = (sp_lo > hi) ? hi : sp_lo;
    end

    // Compact to wide expansion; a shift past the width leaves zero.
    always_comb begin
        size = s_prev_bits[31:24];
        word_ext = TARGET_BITS'(s_prev_bits[22:0]);
        shift = 8'd0;
        sh_bits = 11'd0;
        if (size <= 8'd3) begin
            sh_bits = {(8'd3 - size), 3'b000};
            entry.value = word_ext >> sh_bits;
        end else begin
            shift = size - 8'd3;
            sh_bits = {shift, 3'b000};
            entry.value = word_ext << sh_bits;
        end
    end

    // Classification and the rest of the queue entry.
    always_comb begin
        if (s_chain_short) begin
            entry.kind = KIND_SHORT;
        end else if (!s_mode && cfg.no_retarget) begin
            entry.kind = KIND_KEEP;
        end else if (s_mode) begin
            entry.kind = KIND_AVG;
        end else begin
            entry.kind = KIND_LEGACY;
        end
        entry.prev_bits = s_prev_bits;
        entry.span = sp_hi[SPAN_W-1:0];
    end
endmodule
`default_nettype wire

>>> rtl/ptr_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
`include "pow_target_retarget_defines.svh"
module ptr_queue
    import ptr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output entry_t      head
);
    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `PTR_ASSERT_IMPL(a_no_overflow, push, cnt_reg != 2'd2)
    `PTR_ASSERT_IMPL(a_no_underflow, pop, cnt_reg != 2'd0)
endmodule
`default_nettype wire

>>> rtl/ptr_back.sv
// Back end: serial multiply and divide, limit clamp and compact encoding.
`default_nettype none
`include "pow_target_retarget_defines.svh"
module ptr_back
    import ptr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    input  wire entry_t      q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_new_bits,
    output logic             m_hit_limit
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_CLAMP = 6'b001000,
        ST_NORM  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TARGET_BITS-1:0] val_reg, val_next;
    logic [TARGET_BITS-1:0] mcand_reg, mcand_next;
    logic [SPAN_W-1:0]      mult_reg, mult_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic                   pre_reg, pre_next;
    logic                   avg_reg, avg_next;
    logic                   second_reg, second_next;
    logic                   hit_reg, hit_next;
    logic                   keep_reg, keep_next;
    logic [NB_W-1:0]        nbyte_reg, nbyte_next;
    logic [31:0]            prev_reg, prev_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            new_bits_reg, new_bits_next;
    logic                   hit_limit_reg, hit_limit_next;

    logic [TARGET_BITS-1:0] limit;
    logic [TARGET_BITS-1:0] quot;
    logic [DIV_W:0]         rem_sh;
    logic                   ge;
    logic                   div_last;
    logic [23:0]            mant;
    logic [NB_W-1:0]        nres;
    logic                   out_free;

    assign m_valid = m_valid_reg;
    assign m_new_bits = new_bits_reg;
    assign m_hit_limit = hit_limit_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Limit: all ones below bit TARGET_BITS minus the zero-bit count.
    always_comb begin
        for (int i = 0; i < TARGET_BITS; i++) begin
            limit[i] = (i < (TARGET_BITS - int'(cfg.zero_bits)));
        end
    end

    // One restoring division step, or all ones for a zero divisor.
    always_comb begin
        rem_sh = {rem_reg, val_reg[TARGET_BITS-1]};
        ge = (rem_sh >= {1'b0, div_reg});
        if (div_reg == '0) begin
            quot = '1;
            div_last = 1'b1;
        end else begin
            quot = {val_reg[TARGET_BITS-2:0], ge};
            div_last = (cnt_reg == CNT_W'(1));
        end
    end

    // Compact encoding of the normalized value.
    always_comb begin
        mant = val_reg[TARGET_BITS-1:TARGET_BITS-24];
        nres = nbyte_reg;
        if (mant[23]) begin
            mant = mant >> 8;
            nres = nbyte_reg + NB_W'(1);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        val_next = val_reg;
        mcand_next = mcand_reg;
        mult_next = mult_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        pre_next = pre_reg;
        avg_next = avg_reg;
        second_next = second_reg;
        hit_next = hit_reg;
        keep_next = keep_reg;
        nbyte_next = nbyte_reg;
        prev_next = prev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        new_bits_next = new_bits_reg;
        hit_limit_next = hit_limit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    prev_next = q_head.prev_bits;
                    pre_next = 1'b0;
                    avg_next = 1'b0;
                    second_next = 1'b0;
                    hit_next = 1'b0;
                    keep_next = 1'b0;
                    val_next = '0;
                    mcand_next = q_head.value;
                    mult_next = q_head.span;
                    cnt_next = CNT_W'(SPAN_W);
                    case (q_head.kind)
                        KIND_SHORT: begin
                            val_next = limit;
                            hit_next = 1'b1;
                            nbyte_next = NB_W'(NBYTES);
                            state_next = ST_NORM;
                        end
                        KIND_KEEP: begin
                            keep_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_LEGACY: begin
                            // Pre-shift when the value is as wide as the limit.
                            if ((limit != '0) && (q_head.value > (limit >> 1))) begin
                                pre_next = 1'b1;
                                mcand_next = q_head.value >> 1;
                            end
                            div_next = cfg.legacy_span;
                            state_next = ST_MUL;
                        end
                        default: begin
                            avg_next = 1'b1;
                            div_next = cfg.avg_span;
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                val_next = (val_reg << 1) + (mult_reg[SPAN_W-1] ? mcand_reg : '0);
                mult_next = mult_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next = CNT_W'(TARGET_BITS);
                    rem_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = ge ? DIV_W'(rem_sh - {1'b0, div_reg}) : rem_sh[DIV_W-1:0];
                val_next = quot;
                cnt_next = cnt_reg - CNT_W'(1);
                if (div_last) begin
                    if (avg_reg && !second_reg) begin
                        // Second pass: times 100, over 100 plus the adjustment.
                        second_next = 1'b1;
                        mcand_next = quot;
                        val_next = '0;
                        mult_next = SPAN_W'(ADJ_BASE);
                        cnt_next = CNT_W'(SPAN_W);
                        div_next = DIV_W'(ADJ_BASE) + DIV_W'(cfg.adjust);
                        state_next = ST_MUL;
                    end else begin
                        val_next = pre_reg ? (quot << 1) : quot;
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_CLAMP: begin
                if (val_reg > limit) begin
                    val_next = limit;
                    hit_next = 1'b1;
                end
                nbyte_next = NB_W'(NBYTES);
                state_next = ST_NORM;
            end
            ST_NORM: begin
                // Drop leading zero bytes one a cycle.
                if ((nbyte_reg != '0) && (val_reg[TARGET_BITS-1:TARGET_BITS-8] == 8'd0)) begin
                    val_next = val_reg << 8;
                    nbyte_next = nbyte_reg - NB_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (keep_reg) begin
                        new_bits_next = prev_reg;
                        hit_limit_next = 1'b0;
                    end else begin
                        new_bits_next = {8'(nres), mant};
                        hit_limit_next = hit_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        mcand_reg <= mcand_next;
        mult_reg <= mult_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        pre_reg <= pre_next;
        avg_reg <= avg_next;
        second_reg <= second_next;
        hit_reg <= hit_next;
        keep_reg <= keep_next;
        nbyte_reg <= nbyte_next;
        prev_reg <= prev_next;
        new_bits_reg <= new_bits_next;
        hit_limit_reg <= hit_limit_next;
    end

    `PTR_ASSERT_IMPL(a_pop_idle, q_pop, state_reg == ST_IDLE)
    `PTR_ASSERT_NEXT(a_done_hold, (state_reg == ST_DONE) && !out_free, state_reg == ST_DONE)
endmodule
`default_nettype wire

>>> rtl/pow_target_retarget.sv
// Top level of the difficulty retarget block: register port and the two ends.
// A serial shift-add multiplier (34 steps), a restoring divider (256 steps) and byte
// normalization do the work; averaging mode runs the multiply and divide twice, while
// short-chain items skip to normalization and items that keep their bits skip both.
// A two-item queue takes new items while one runs; the back end works on one item at a time.
// Reset: synchronous, active low; clears the queue and sequencer and loads register defaults.
`default_nettype none
module pow_target_retarget
    import ptr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [31:0] s_prev_bits,
    input  wire logic [31:0] s_first_time,
    input  wire logic [31:0] s_last_time,
    input  wire logic        s_chain_short,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_new_bits,
    output logic             m_hit_limit
);
    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    entry_t   push_entry;
    entry_t   q_head;

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[4:2]);
    assign wr_en = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.legacy_span <= 32'd1209600;
            cfg_reg.avg_span <= 32'd600;
            cfg_reg.avg_min <= 32'd480;
            cfg_reg.avg_max <= 32'd720;
            cfg_reg.adjust <= 16'd4;
            cfg_reg.zero_bits <= 8'd20;
            cfg_reg.no_retarget <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_LEGACY_SPAN: cfg_reg.legacy_span <= pwdata;
                REG_AVG_SPAN:    cfg_reg.avg_span <= pwdata;
                REG_AVG_MIN:     cfg_reg.avg_min <= pwdata;
                REG_AVG_MAX:     cfg_reg.avg_max <= pwdata;
                REG_ADJUST:      cfg_reg.adjust <= pwdata[15:0];
                REG_ZERO_BITS:   cfg_reg.zero_bits <= pwdata[7:0];
                REG_NO_RETARGET: cfg_reg.no_retarget <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (idx)
            REG_LEGACY_SPAN: prdata = cfg_reg.legacy_span;
            REG_AVG_SPAN:    prdata = cfg_reg.avg_span;
            REG_AVG_MIN:     prdata = cfg_reg.avg_min;
            REG_AVG_MAX:     prdata = cfg_reg.avg_max;
            REG_ADJUST:      prdata = {16'd0, cfg_reg.adjust};
            REG_ZERO_BITS:   prdata = {24'd0, cfg_reg.zero_bits};
            REG_NO_RETARGET: prdata = {31'd0, cfg_reg.no_retarget};
            default:         prdata = 32'd0;
        endcase
    end

    ptr_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_prev_bits   (s_prev_bits),
        .s_first_time  (s_first_time),
        .s_last_time   (s_last_time),
        .s_chain_short (s_chain_short),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .push          (push),
        .entry         (push_entry)
    );

    ptr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    ptr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_bits  (m_new_bits),
        .m_hit_limit (m_hit_limit)
    );
endmodule
`default_nettype wire

>>> tb/sv/retarget_checker.sv
// Checker of the retarget block: mirrors the registers, predicts each result and compares it.
`timescale 1ns / 100ps
module retarget_checker
    import ptr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_prev_bits,
    input  logic [31:0] s_first_time,
    input  logic [31:0] s_last_time,
    input  logic        s_chain_short,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_new_bits,
    input  logic        m_hit_limit,
    output int          fail_count,
    output int          pending
);
    typedef logic [TARGET_BITS-1:0] target_t;

    typedef struct {
        logic [31:0] new_bits;
        logic        hit_limit;
    } retarget_t;

    retarget_t   awaited_targets[$];
    logic [31:0] legacy_span, avg_span, avg_min, avg_max;
    logic [15:0] adjust;
    logic [7:0]  zero_bits;
    logic        no_retarget;

    // Position of the highest set bit plus one, zero for a zero value.
    function automatic int bit_length(target_t a);
        for (int i = TARGET_BITS - 1; i >= 0; i--) begin
            if (a[i]) return i + 1;
        end
        return 0;
    endfunction

    // Compact form to full-width target; the sign bit is dropped.
    function automatic target_t unpack_target(logic [31:0] bits);
        int      size;
        target_t word;
        size = bits[31:24];
        word = target_t'(bits[22:0]);
        if (size <= 3) return word >> (8 * (3 - size));
        return word << (8 * (size - 3));
    endfunction

    // Full-width target to compact form.
    function automatic logic [31:0] pack_target(target_t a);
        int          n;
        logic [31:0] c;
        n = (bit_length(a) + 7) / 8;
        if (n <= 3) c = 32'(a[63:0] << (8 * (3 - n)));
        else c = 32'(a >> (8 * (n - 3)));
        if (c[23]) begin
            c = c >> 8;
            n++;
        end
        return c | (32'(n) << 24);
    endfunction

    // Divide, with a zero divisor giving all ones.
    function automatic target_t div_target(target_t a, longint unsigned d);
        if (d == 0) return '1;
        return a / target_t'(d);
    endfunction

    function automatic retarget_t retarget_predict(logic mode, logic [31:0] prev,
                                                   logic [31:0] first, logic [31:0] last,
                                                   logic short_chain);
        retarget_t r;
        target_t   limit, v;
        int        limit_len;
        longint    span, lo, hi;
        logic      pre;
        limit = target_t'('1) >> zero_bits;
        limit_len = bit_length(limit);
        r.hit_limit = 1'b0;
        if (short_chain) begin
            r.new_bits = pack_target(limit);
            r.hit_limit = 1'b1;
            return r;
        end
        if (!mode && no_retarget) begin
            r.new_bits = prev;
            return r;
        end
        span = longint'(last) - longint'(first);
        v = unpack_target(prev);
        if (!mode) begin
            // Legacy: clamp to a quarter and four times the target span.
            lo = longint'(legacy_span / 4);
            hi = longint'(legacy_span) * 4;
            if (span < lo) span = lo;
            if (span > hi) span = hi;
            pre = limit_len > 0 && bit_length(v) >= limit_len;
            if (pre) v = v >> 1;
            v = v * target_t'(span);
            v = div_target(v, legacy_span);
            if (pre) v = v << 1;
        end else begin
            // Averaging: clamp low bound first, then high bound; scale by the span, then by the adjustment.
            if (span < longint'(avg_min)) span = longint'(avg_min);
            if (span > longint'(avg_max)) span = longint'(avg_max);
            v = v * target_t'(span);
            v = div_target(v, avg_span);
            v = v * target_t'(ADJ_BASE);
            v = div_target(v, ADJ_BASE + adjust);
        end
        if (v > limit) begin
            v = limit;
            r.hit_limit = 1'b1;
        end
        r.new_bits = pack_target(v);
        return r;
    endfunction

    assign pending = awaited_targets.size();

    // Register mirror, prediction on each accepted item, comparison on each result.
    always @(posedge aclk) begin
        retarget_t want;
        if (!aresetn) begin
            legacy_span <= 32'd1209600;
            avg_span    <= 32'd600;
            avg_min     <= 32'd480;
            avg_max     <= 32'd720;
            adjust      <= 16'd4;
            zero_bits   <= 8'd20;
            no_retarget <= 1'b0;
            fail_count  <= 0;
            awaited_targets.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_LEGACY_SPAN: legacy_span <= pwdata;
                    REG_AVG_SPAN:    avg_span <= pwdata;
                    REG_AVG_MIN:     avg_min <= pwdata;
                    REG_AVG_MAX:     avg_max <= pwdata;
                    REG_ADJUST:      adjust <= pwdata[15:0];
                    REG_ZERO_BITS:   zero_bits <= pwdata[7:0];
                    REG_NO_RETARGET: no_retarget <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                awaited_targets.push_back(retarget_predict(s_mode, s_prev_bits, s_first_time,
                                                           s_last_time, s_chain_short));
            end
            if (m_valid && m_ready) begin
                if (awaited_targets.size() == 0) begin
                    $display("%0t: result %h/%b with no item outstanding", $time,
                             m_new_bits, m_hit_limit);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_targets.pop_front();
                    if (want.new_bits !== m_new_bits || want.hit_limit !== m_hit_limit) begin
                        $display("%0t: new_bits exp %h got %h, hit_limit exp %b got %b",
                                 $time, want.new_bits, m_new_bits, want.hit_limit,
                                 m_hit_limit);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
// Testbench top of the retarget block: stimulus, register phases and verdict.
`timescale 1ns / 100ps
module tb;
    import ptr_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready;
    logic        s_mode = 1'b0, s_chain_short = 1'b0;
    logic [31:0] s_prev_bits = '0, s_first_time = '0, s_last_time = '0;
    logic        m_valid, m_ready = 1'b0;
    logic [31:0] m_new_bits;
    logic        m_hit_limit;
    int          fail_count, pending;
    logic        no_idle = 1'b0;
    int          quiet_cycles = 0;
    int          drain_stall = 0;

    always #5 aclk = ~aclk;

    pow_target_retarget dut (.*);
    retarget_checker checker_i (.*);

    // Result side: random stall bursts, none in the last part of the run.
    always @(posedge aclk) begin
        if (no_idle || !aresetn) begin
            m_ready <= 1'b1;
        end else if (drain_stall > 0) begin
            drain_stall <= drain_stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 2) begin
            drain_stall <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(logic [31:0] lspan, logic [31:0] aspan, logic [31:0] amin,
                             logic [31:0] amax, logic [15:0] adj, logic [7:0] zb,
                             logic keep);
        reg_write(REG_LEGACY_SPAN, lspan);
        reg_write(REG_AVG_SPAN, aspan);
        reg_write(REG_AVG_MIN, amin);
        reg_write(REG_AVG_MAX, amax);
        reg_write(REG_ADJUST, 32'(adj));
        reg_write(REG_ZERO_BITS, 32'(zb));
        reg_write(REG_NO_RETARGET, 32'(keep));
    endtask

    // Stop offering items and wait until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Offer one item and hold it until it is taken, then maybe idle.
    task automatic send_request(logic mode, logic [31:0] prev, logic [31:0] first,
                                logic [31:0] last, logic short_chain);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_prev_bits <= prev;
        s_first_time <= first;
        s_last_time <= last;
        s_chain_short <= short_chain;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Random item: mostly plausible exponents and spans around the clamp bounds.
    task automatic random_request();
        logic [31:0] prev, first, delta;
        prev = $urandom;
        if ($urandom_range(0, 3) != 0) prev[31:24] = $urandom_range(0, 34);
        first = $urandom;
        case ($urandom_range(0, 4))
            0: delta = $urandom;
            1: delta = $urandom_range(0, 2000);
            2: delta = $urandom_range(200000, 6000000);
            3: delta = -$urandom_range(0, 1000);
            default: delta = $urandom_range(0, 32'hffff);
        endcase
        send_request($urandom_range(0, 1), prev, first, first + delta,
                     $urandom_range(0, 9) == 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset values.
        send_request(1'b0, 32'h1d00ffff, 32'd0, 32'd1209600, 1'b0);
        send_request(1'b1, 32'h1d00ffff, 32'd1000, 32'd1600, 1'b0);
        send_request(1'b0, 32'h1d00ffff, 32'd0, 32'd0, 1'b1);
        send_request(1'b1, 32'hffffffff, 32'hffffffff, 32'd0, 1'b1);
        send_request(1'b0, 32'h00000000, 32'd0, 32'hffffffff, 1'b0);
        send_request(1'b0, 32'h01123456, 32'd5, 32'd1, 1'b0);
        send_request(1'b1, 32'h02923456, 32'd0, 32'd100, 1'b0);
        send_request(1'b0, 32'h03ffffff, 32'hffffffff, 32'd0, 1'b0);
        send_request(1'b1, 32'h04800001, 32'd0, 32'hffffffff, 1'b0);
        send_request(1'b0, 32'h1f7fffff, 32'd0, 32'd4838400, 1'b0);
        send_request(1'b0, 32'h21ffffff, 32'd0, 32'd9999999, 1'b0);
        send_request(1'b1, 32'h207fffff, 32'd0, 32'd720, 1'b0);
        send_request(1'b0, 32'hff7fffff, 32'd0, 32'd1209600, 1'b0);
        send_request(1'b1, 32'h80000001, 32'd10, 32'd490, 1'b0);
        send_request(1'b0, 32'h1b012345, 32'd100, 32'd302499, 1'b0);
        drain_results();

        // Low extremes of the registers.
        load_regs(32'd4, 32'd1, 32'd1, 32'hffffffff, 16'd0, 8'd1, 1'b0);
        send_request(1'b0, 32'h207fffff, 32'd0, 32'd0, 1'b0);
        send_request(1'b0, 32'h21ffffff, 32'd0, 32'd16, 1'b0);
        send_request(1'b1, 32'h217fffff, 32'd0, 32'hffffffff, 1'b0);
        repeat (200) random_request();
        drain_results();

        // High extremes, with retargeting off in legacy mode.
        load_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'd1, 16'hffff, 8'd255, 1'b1);
        send_request(1'b0, 32'h1d00ffff, 32'd0, 32'd0, 1'b0);
        send_request(1'b1, 32'h217fffff, 32'd0, 32'd0, 1'b0);
        send_request(1'b0, 32'h1d00ffff, 32'd0, 32'd0, 1'b1);
        repeat (150) random_request();
        drain_results();

        // Random register settings.
        for (int ph = 0; ph < 3; ph++) begin
            load_regs($urandom_range(4, 32'hffffffff), $urandom_range(1, 32'h0fffffff),
                      $urandom_range(1, 5000), $urandom_range(1, 32'h0fffffff),
                      $urandom_range(0, 16'hffff), $urandom_range(1, 255),
                      $urandom_range(0, 1));
            repeat (150) random_request();
            drain_results();
        end

        // Back to the reset values, with no idling on either side.
        load_regs(32'd1209600, 32'd600, 32'd480, 32'd720, 16'd4, 8'd20, 1'b0);
        no_idle <= 1'b1;
        repeat (200) random_request();
        drain_results();
        repeat (50) @(posedge aclk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/ptr_pkg.sv
rtl/ptr_front.sv
rtl/ptr_queue.sv
rtl/ptr_back.sv
rtl/pow_target_retarget.sv
tb/sv/retarget_checker.sv
tb/sv/tb.sv
